// ===== sv/sns_pkg.sv =====
// ============================================================================
// sns_pkg
// Shared types and constants for the signed nearest segment distance block.
// ============================================================================
`default_nettype none

package sns_pkg;

    localparam int MAX_SEG_DEF   = 64;
    localparam int COORD_DEF     = 32;
    localparam int CNT_W         = 7;
    localparam int IDX_W         = 6;
    localparam int DIST_W        = 48;
    localparam int FRAC_W        = 16;
    localparam logic [DIST_W-1:0] DIST_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic OP_LOAD_CODE  = 1'b0;
    localparam logic OP_QUERY_CODE = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_READ, ST_DIFF, ST_L2A, ST_L2B, ST_DPA, ST_DPB, ST_DPC,
        ST_CHK, ST_DIV, ST_TXA, ST_TXB, ST_TXC, ST_SQA, ST_SQB, ST_SQC,
        ST_CPA, ST_CPB, ST_CPC, ST_CLA, ST_CLB, ST_CMP, ST_RINIT, ST_ROOT,
        ST_FIN, ST_EMPTY
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_QUERY, OP_DIFF, OP_L2A, OP_L2B, OP_DPA, OP_DPB,
        OP_DPC, OP_PICK_V, OP_PICK_W, OP_DIV_INIT, OP_DIV, OP_TXA, OP_TXB,
        OP_TXC, OP_SQA, OP_SQB, OP_SQC, OP_CPA, OP_CPB, OP_CPC, OP_CLA,
        OP_CLB, OP_CMP, OP_RINIT, OP_ROOT, OP_FIN, OP_EMPTY
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic l2_zero;
        logic dp_nonpos;
        logic dp_ge;
        logic div_last;
        logic seg_last;
        logic root_last;
    } t_sts;

endpackage

`default_nettype wire

// ===== sv/signed_nearest_segment_distance.sv =====
// ============================================================================
// signed_nearest_segment_distance
// Signed distance from a point to the nearest of the loaded track segments.
// ============================================================================
// Operation: a load is written from idle and busy stays low. A query holds busy
// while the n segments are searched: each segment is stepped through the shared
// multiplier, with a divide and an offset when the point projects inside it
// (16 divider steps, 3 offset steps), then one root bit per cycle. The strobe
// comes in the same cycle that busy drops, and results cannot be stalled; an
// empty table holds busy only for ST_EMPTY. Reset clears sequencer, count and strobe.
`default_nettype none

module signed_nearest_segment_distance
    import sns_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEG_DEF,
    parameter int COORD_BITS   = COORD_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [CNT_W-1:0]             i_cfg_wdata,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         i_op,
    input  wire logic [IDX_W-1:0]             i_seg_index,
    input  wire logic signed [COORD_BITS-1:0] i_start_x,
    input  wire logic signed [COORD_BITS-1:0] i_start_y,
    input  wire logic signed [COORD_BITS-1:0] i_end_x,
    input  wire logic signed [COORD_BITS-1:0] i_end_y,
    input  wire logic signed [COORD_BITS-1:0] i_left_x,
    input  wire logic signed [COORD_BITS-1:0] i_left_y,
    input  wire logic signed [COORD_BITS-1:0] i_point_x,
    input  wire logic signed [COORD_BITS-1:0] i_point_y,
    output logic                              o_valid,
    output logic signed [DIST_W-1:0]          o_signed_distance,
    output logic [IDX_W-1:0]                  o_nearest_index,
    output logic                              o_no_segments
);

    t_cmd cmd;
    t_sts sts;

    sns_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_op    (i_op),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    sns_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_seg_index       (i_seg_index),
        .i_start_x         (i_start_x),
        .i_start_y         (i_start_y),
        .i_end_x           (i_end_x),
        .i_end_y           (i_end_y),
        .i_left_x          (i_left_x),
        .i_left_y          (i_left_y),
        .i_point_x         (i_point_x),
        .i_point_y         (i_point_y),
        .o_valid           (o_valid),
        .o_signed_distance (o_signed_distance),
        .o_nearest_index   (o_nearest_index),
        .o_no_segments     (o_no_segments)
    );

endmodule

`default_nettype wire

// ===== sv/sns_ctrl.sv =====
// ============================================================================
// sns_ctrl
// Sequencer: steps the datapath through each segment, the divide and the root.
// ============================================================================
`default_nettype none

module sns_ctrl
    import sns_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire logic i_op,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start && (i_op == OP_QUERY_CODE)) begin
                    n_state = i_sts.empty ? ST_EMPTY : ST_READ;
                end
            end
            ST_READ:  n_state = ST_DIFF;
            ST_DIFF:  n_state = ST_L2A;
            ST_L2A:   n_state = ST_L2B;
            ST_L2B:   n_state = ST_DPA;
            ST_DPA:   n_state = ST_DPB;
            ST_DPB:   n_state = ST_DPC;
            ST_DPC:   n_state = ST_CHK;
            ST_CHK: begin
                if (i_sts.l2_zero || i_sts.dp_nonpos || i_sts.dp_ge) begin
                    n_state = ST_SQA;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV:   n_state = i_sts.div_last ? ST_TXA : ST_DIV;
            ST_TXA:   n_state = ST_TXB;
            ST_TXB:   n_state = ST_TXC;
            ST_TXC:   n_state = ST_SQA;
            ST_SQA:   n_state = ST_SQB;
            ST_SQB:   n_state = ST_SQC;
            ST_SQC:   n_state = ST_CPA;
            ST_CPA:   n_state = ST_CPB;
            ST_CPB:   n_state = ST_CPC;
            ST_CPC:   n_state = ST_CLA;
            ST_CLA:   n_state = ST_CLB;
            ST_CLB:   n_state = ST_CMP;
            ST_CMP:   n_state = i_sts.seg_last ? ST_RINIT : ST_READ;
            ST_RINIT: n_state = ST_ROOT;
            ST_ROOT:  n_state = i_sts.root_last ? ST_FIN : ST_ROOT;
            ST_FIN:   n_state = ST_IDLE;
            ST_EMPTY: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op = OP_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.op = (i_op == OP_QUERY_CODE) ? OP_QUERY : OP_LOAD;
                end
            end
            ST_READ:  o_cmd.op = OP_NONE;
            ST_DIFF:  o_cmd.op = OP_DIFF;
            ST_L2A:   o_cmd.op = OP_L2A;
            ST_L2B:   o_cmd.op = OP_L2B;
            ST_DPA:   o_cmd.op = OP_DPA;
            ST_DPB:   o_cmd.op = OP_DPB;
            ST_DPC:   o_cmd.op = OP_DPC;
            ST_CHK: begin
                if (i_sts.l2_zero || i_sts.dp_nonpos) begin
                    o_cmd.op = OP_PICK_V;
                end else if (i_sts.dp_ge) begin
                    o_cmd.op = OP_PICK_W;
                end else begin
                    o_cmd.op = OP_DIV_INIT;
                end
            end
            ST_DIV:   o_cmd.op = OP_DIV;
            ST_TXA:   o_cmd.op = OP_TXA;
            ST_TXB:   o_cmd.op = OP_TXB;
            ST_TXC:   o_cmd.op = OP_TXC;
            ST_SQA:   o_cmd.op = OP_SQA;
            ST_SQB:   o_cmd.op = OP_SQB;
            ST_SQC:   o_cmd.op = OP_SQC;
            ST_CPA:   o_cmd.op = OP_CPA;
            ST_CPB:   o_cmd.op = OP_CPB;
            ST_CPC:   o_cmd.op = OP_CPC;
            ST_CLA:   o_cmd.op = OP_CLA;
            ST_CLB:   o_cmd.op = OP_CLB;
            ST_CMP:   o_cmd.op = OP_CMP;
            ST_RINIT: o_cmd.op = OP_RINIT;
            ST_ROOT:  o_cmd.op = OP_ROOT;
            ST_FIN:   o_cmd.op = OP_FIN;
            ST_EMPTY: o_cmd.op = OP_EMPTY;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

// ===== sv/sns_dp.sv =====
// ============================================================================
// sns_dp
// Datapath: segment table, shared multiplier, restoring divider, root unit.
// ============================================================================
`default_nettype none

module sns_dp
    import sns_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEG_DEF,
    parameter int COORD_BITS   = COORD_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_cmd                         i_cmd,
    output t_sts                              o_sts,
    input  wire logic                         i_cfg_we,
    input  wire logic [CNT_W-1:0]             i_cfg_wdata,
    input  wire logic [IDX_W-1:0]             i_seg_index,
    input  wire logic signed [COORD_BITS-1:0] i_start_x,
    input  wire logic signed [COORD_BITS-1:0] i_start_y,
    input  wire logic signed [COORD_BITS-1:0] i_end_x,
    input  wire logic signed [COORD_BITS-1:0] i_end_y,
    input  wire logic signed [COORD_BITS-1:0] i_left_x,
    input  wire logic signed [COORD_BITS-1:0] i_left_y,
    input  wire logic signed [COORD_BITS-1:0] i_point_x,
    input  wire logic signed [COORD_BITS-1:0] i_point_y,
    output logic                              o_valid,
    output logic signed [DIST_W-1:0]          o_signed_distance,
    output logic [IDX_W-1:0]                  o_nearest_index,
    output logic                              o_no_segments
);

    localparam int CW   = COORD_BITS;
    localparam int AW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int MW   = CW + 2;
    localparam int PW   = 2 * CW + 4;
    localparam int ACW  = 2 * CW + 5;
    localparam int SW   = CW + 5;
    localparam int EW   = 16;
    localparam int DW   = 6 * CW;
    localparam int CTW  = $clog2(MW + 1);
    localparam logic [EW-1:0] MAX_EXT = EW'(MAX_SEGMENTS);
    localparam logic [CTW-1:0] DIV_LAST  = CTW'(FRAC_W - 1);
    localparam logic [CTW-1:0] ROOT_LAST = CTW'(MW - 1);

    logic [DW-1:0]           r_mem [MAX_SEGMENTS];
    logic [DW-1:0]           r_rd;
    logic [CNT_W-1:0]        r_count;
    logic signed [CW-1:0]    r_px, r_py;
    logic [AW-1:0]           r_idx;
    logic signed [CW:0]      r_ax, r_ay, r_dx, r_dy, r_bx, r_by, r_lx, r_ly;
    logic signed [MW-1:0]    r_ex, r_ey;
    logic signed [PW-1:0]    r_prod;
    logic signed [ACW-1:0]   r_acc, r_l2, r_dp;
    logic [ACW-1:0]          r_rem;
    logic [FRAC_W-1:0]       r_t;
    logic [CTW-1:0]          r_cnt;
    logic [PW-1:0]           r_d2, r_best, r_rad;
    logic                    r_cp_neg, r_side, r_best_side;
    logic [AW-1:0]           r_best_i;
    logic [MW-1:0]           r_root;
    logic [SW-1:0]           r_srem;
    logic                    r_valid;
    logic signed [DIST_W-1:0] r_dist;
    logic [IDX_W-1:0]        r_nidx;
    logic                    r_noseg;

    logic signed [CW-1:0]    rd_sx, rd_sy, rd_ex, rd_ey, rd_lx, rd_ly;
    logic signed [MW-1:0]    m_a, m_b;
    logic signed [ACW-1:0]   sum_ap, dif_ap;
    logic signed [PW-1:0]    shr_prod, ex_wide;
    logic [ACW-1:0]          rem2;
    logic [EW-1:0]           widx, nlim, idx_next;
    logic                    wr_en;
    logic [SW-1:0]           srem_sh, trial;
    logic [63:0]             root64, mag64;
    logic [DIST_W-1:0]       mag;

    assign {rd_lx, rd_ly, rd_ex, rd_ey, rd_sx, rd_sy} = r_rd;

    assign widx  = EW'(i_seg_index);
    assign wr_en = (i_cmd.op == OP_LOAD) && (widx < MAX_EXT);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[widx[AW-1:0]] <= {i_left_x, i_left_y, i_end_x, i_end_y,
                                    i_start_x, i_start_y};
        end
        r_rd <= r_mem[r_idx];
    end

    assign nlim     = (EW'(r_count) > MAX_EXT) ? MAX_EXT : EW'(r_count);
    assign idx_next = EW'(r_idx) + EW'(1);

    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (i_cmd.op)
            OP_L2A:  begin m_a = MW'(r_dx); m_b = MW'(r_dx); end
            OP_L2B:  begin m_a = MW'(r_dy); m_b = MW'(r_dy); end
            OP_DPA:  begin m_a = MW'(r_ax); m_b = MW'(r_dx); end
            OP_DPB:  begin m_a = MW'(r_ay); m_b = MW'(r_dy); end
            OP_TXA:  begin m_a = $signed(MW'(r_t)); m_b = MW'(r_dx); end
            OP_TXB:  begin m_a = $signed(MW'(r_t)); m_b = MW'(r_dy); end
            OP_SQA:  begin m_a = r_ex; m_b = r_ex; end
            OP_SQB:  begin m_a = r_ey; m_b = r_ey; end
            OP_CPA:  begin m_a = MW'(r_ax); m_b = MW'(r_dy); end
            OP_CPB:  begin m_a = MW'(r_ay); m_b = MW'(r_dx); end
            OP_CPC:  begin m_a = MW'(r_lx); m_b = MW'(r_dy); end
            OP_CLA:  begin m_a = MW'(r_ly); m_b = MW'(r_dx); end
            default: begin m_a = '0; m_b = '0; end
        endcase
    end

    assign sum_ap   = r_acc + ACW'(r_prod);
    assign dif_ap   = r_acc - ACW'(r_prod);
    assign shr_prod = r_prod >>> FRAC_W;
    assign ex_wide  = (i_cmd.op == OP_TXB) ? (PW'(r_ax) - shr_prod)
                                           : (PW'(r_ay) - shr_prod);
    assign rem2     = r_rem << 1;
    assign srem_sh  = {r_srem[SW-3:0], r_rad[PW-1:PW-2]};
    assign trial    = SW'({r_root, 2'b01});

    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
        unique case (i_cmd.op)
            OP_QUERY: begin
                r_px  <= i_point_x;
                r_py  <= i_point_y;
                r_idx <= '0;
            end
            OP_DIFF: begin
                r_ax <= (CW+1)'(r_px) - (CW+1)'(rd_sx);
                r_ay <= (CW+1)'(r_py) - (CW+1)'(rd_sy);
                r_dx <= (CW+1)'(rd_ex) - (CW+1)'(rd_sx);
                r_dy <= (CW+1)'(rd_ey) - (CW+1)'(rd_sy);
                r_bx <= (CW+1)'(r_px) - (CW+1)'(rd_ex);
                r_by <= (CW+1)'(r_py) - (CW+1)'(rd_ey);
                r_lx <= (CW+1)'(rd_lx) - (CW+1)'(rd_sx);
                r_ly <= (CW+1)'(rd_ly) - (CW+1)'(rd_sy);
            end
            OP_L2B, OP_DPB, OP_SQB, OP_CPB, OP_CLA: r_acc <= ACW'(r_prod);
            OP_DPA: r_l2 <= sum_ap;
            OP_DPC: r_dp <= sum_ap;
            OP_PICK_V: begin
                r_ex <= MW'(r_ax);
                r_ey <= MW'(r_ay);
            end
            OP_PICK_W: begin
                r_ex <= MW'(r_bx);
                r_ey <= MW'(r_by);
            end
            OP_DIV_INIT: begin
                r_rem <= r_dp;
                r_t   <= '0;
                r_cnt <= '0;
            end
            OP_DIV: begin
                if (rem2 >= r_l2) begin
                    r_rem <= rem2 - r_l2;
                    r_t   <= {r_t[FRAC_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem2;
                    r_t   <= {r_t[FRAC_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + CTW'(1);
            end
            OP_TXB: r_ex <= ex_wide[MW-1:0];
            OP_TXC: r_ey <= ex_wide[MW-1:0];
            OP_SQC: r_d2 <= sum_ap[PW-1:0];
            OP_CPC: r_cp_neg <= dif_ap[ACW-1];
            OP_CLB: r_side <= (r_cp_neg == dif_ap[ACW-1]);
            OP_CMP: begin
                if ((r_idx == '0) || (r_d2 < r_best)) begin
                    r_best      <= r_d2;
                    r_best_i    <= r_idx;
                    r_best_side <= r_side;
                end
                r_idx <= idx_next[AW-1:0];
            end
            OP_RINIT: begin
                r_rad  <= r_best;
                r_root <= '0;
                r_srem <= '0;
                r_cnt  <= '0;
            end
            OP_ROOT: begin
                if (srem_sh >= trial) begin
                    r_srem <= srem_sh - trial;
                    r_root <= {r_root[MW-2:0], 1'b1};
                end else begin
                    r_srem <= srem_sh;
                    r_root <= {r_root[MW-2:0], 1'b0};
                end
                r_rad <= r_rad << 2;
                r_cnt <= r_cnt + CTW'(1);
            end
            default: begin
            end
        endcase
    end

    assign root64 = 64'(r_root);
    assign mag64  = (root64 > 64'(DIST_MAX)) ? 64'(DIST_MAX) : root64;
    assign mag    = mag64[DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            r_valid <= (i_cmd.op == OP_FIN) || (i_cmd.op == OP_EMPTY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_FIN) begin
            r_dist  <= r_best_side ? $signed(mag) : -$signed(mag);
            r_nidx  <= IDX_W'(EW'(r_best_i));
            r_noseg <= 1'b0;
        end else if (i_cmd.op == OP_EMPTY) begin
            r_dist  <= $signed(DIST_MAX);
            r_nidx  <= '0;
            r_noseg <= 1'b1;
        end
    end

    assign o_sts.empty     = (r_count == '0);
    assign o_sts.l2_zero   = (r_l2 == '0);
    assign o_sts.dp_nonpos = (r_dp <= 0);
    assign o_sts.dp_ge     = (r_dp >= r_l2);
    assign o_sts.div_last  = (r_cnt == DIV_LAST);
    assign o_sts.seg_last  = (idx_next == nlim);
    assign o_sts.root_last = (r_cnt == ROOT_LAST);

    assign o_valid           = r_valid;
    assign o_signed_distance = r_dist;
    assign o_nearest_index   = r_nidx;
    assign o_no_segments     = r_noseg;

endmodule

`default_nettype wire

// ===== sv/sns_chk.sv =====
// ============================================================================
// sns_chk
// Port-level checks on request acceptance and result strobes.
// ============================================================================
`default_nettype none

module sns_chk
    import sns_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              i_op,
    input wire logic              o_valid,
    input wire logic [DIST_W-1:0] o_signed_distance,
    input wire logic [IDX_W-1:0]  o_nearest_index,
    input wire logic              o_no_segments
);

    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held");

    a_idle_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result while busy");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == OP_LOAD_CODE)) |=> (!busy && !o_valid))
        else $error("load request held the block");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == OP_QUERY_CODE)) |=> busy)
        else $error("query request not taken");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_no_segments) |->
            ((o_signed_distance == DIST_MAX) && (o_nearest_index == '0)))
        else $error("empty result not saturated");

endmodule

bind signed_nearest_segment_distance sns_chk u_sns_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .i_op              (i_op),
    .o_valid           (o_valid),
    .o_signed_distance (o_signed_distance),
    .o_nearest_index   (o_nearest_index),
    .o_no_segments     (o_no_segments)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// ============================================================================
// tb_top
// Self-checking bench for signed_nearest_segment_distance. Segment loads and
// point queries go in through the start/busy port. A predictor of its own
// works out the expected signed distance, nearest index and empty flag with
// exact wide-integer arithmetic and checks every strobed result in order.
// ============================================================================
module tb_top;
    import sns_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSEG        = MAX_SEG_DEF;
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int Q           = 65536;

    typedef struct {
        logic                    op;
        logic [IDX_W-1:0]        idx;
        logic signed [31:0]      sx, sy, ex, ey, lx, ly, px, py;
    } t_request;

    typedef struct {
        logic [DIST_W-1:0] sdist;
        logic [IDX_W-1:0]  nidx;
        logic              empty;
    } t_answer;

    logic                    i_clk, i_rst_n;
    logic                    i_cfg_we;
    logic [CNT_W-1:0]        i_cfg_wdata;
    logic                    start;
    logic                    busy;
    logic                    i_op;
    logic [IDX_W-1:0]        i_seg_index;
    logic signed [31:0]      i_start_x, i_start_y, i_end_x, i_end_y;
    logic signed [31:0]      i_left_x, i_left_y, i_point_x, i_point_y;
    logic                    o_valid;
    logic signed [DIST_W-1:0] o_signed_distance;
    logic [IDX_W-1:0]        o_nearest_index;
    logic                    o_no_segments;

    signed_nearest_segment_distance u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .start(start), .busy(busy),
        .i_op(i_op), .i_seg_index(i_seg_index),
        .i_start_x(i_start_x), .i_start_y(i_start_y),
        .i_end_x(i_end_x), .i_end_y(i_end_y),
        .i_left_x(i_left_x), .i_left_y(i_left_y),
        .i_point_x(i_point_x), .i_point_y(i_point_y),
        .o_valid(o_valid), .o_signed_distance(o_signed_distance),
        .o_nearest_index(o_nearest_index), .o_no_segments(o_no_segments)
    );

    logic signed [31:0] tbl_sx[NSEG], tbl_sy[NSEG], tbl_ex[NSEG], tbl_ey[NSEG];
    logic signed [31:0] tbl_lx[NSEG], tbl_ly[NSEG];
    bit                 tbl_written[NSEG];
    logic [CNT_W-1:0]   seg_count;

    t_answer expected_answers[$];
    int      error_count, cycle_count, queries_sent, loads_sent, answers_seen;
    int      sender_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [127:0] seg_dist_sq(int i, logic signed [127:0] px,
                                                 logic signed [127:0] py);
        logic signed [127:0] vx, vy, wx, wy, ax, ay, dx, dy, l2, dp, t, ox, oy;
        vx = tbl_sx[i]; vy = tbl_sy[i]; wx = tbl_ex[i]; wy = tbl_ey[i];
        ax = px - vx; ay = py - vy; dx = wx - vx; dy = wy - vy;
        l2 = dx * dx + dy * dy;
        dp = ax * dx + ay * dy;
        if (l2 == 0 || dp <= 0) return ax * ax + ay * ay;
        if (dp >= l2) return (px - wx) * (px - wx) + (py - wy) * (py - wy);
        t  = (dp <<< FRAC_W) / l2;
        ox = (t * dx) >>> FRAC_W;
        oy = (t * dy) >>> FRAC_W;
        return (ax - ox) * (ax - ox) + (ay - oy) * (ay - oy);
    endfunction

    function automatic t_answer nearest_segment(logic signed [31:0] qx,
                                                logic signed [31:0] qy);
        t_answer             a;
        int                  n, best_i;
        logic [127:0]        best, d, c, root;
        logic signed [127:0] px, py, vx, vy, cp, cl;
        logic [63:0]         sd;
        n = (seg_count > NSEG) ? NSEG : seg_count;
        if (n == 0) begin
            a.sdist = DIST_MAX; a.nidx = '0; a.empty = 1'b1;
            return a;
        end
        px = qx; py = qy;
        best = '0; best_i = 0;
        for (int i = 0; i < n; i++) begin
            d = seg_dist_sq(i, px, py);
            if (i == 0 || d < best) begin
                best = d; best_i = i;
            end
        end
        root = '0;
        for (int b = 55; b >= 0; b--) begin
            c = root | (128'd1 << b);
            if (c * c <= best) root = c;
        end
        sd = root[63:0];
        if (sd > DIST_MAX) sd = DIST_MAX;
        vx = tbl_sx[best_i]; vy = tbl_sy[best_i];
        cp = (px - vx) * (tbl_ey[best_i] - vy) - (py - vy) * (tbl_ex[best_i] - vx);
        cl = (tbl_lx[best_i] - vx) * (tbl_ey[best_i] - vy)
           - (tbl_ly[best_i] - vy) * (tbl_ex[best_i] - vx);
        if (cp[127] != cl[127]) sd = -sd;
        a.sdist = sd[DIST_W-1:0]; a.nidx = best_i[IDX_W-1:0]; a.empty = 1'b0;
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n && o_valid) begin
            answers_seen++;
            if (expected_answers.size() == 0) begin
                $error("unexpected result: distance %0d index %0d",
                       o_signed_distance, o_nearest_index);
                error_count++;
            end else begin
                e = expected_answers.pop_front();
                if (o_signed_distance !== e.sdist) begin
                    $error("signed_distance expected %0d got %0d",
                           $signed(e.sdist), o_signed_distance);
                    error_count++;
                end
                if (o_nearest_index !== e.nidx) begin
                    $error("nearest_index expected %0d got %0d", e.nidx, o_nearest_index);
                    error_count++;
                end
                if (o_no_segments !== e.empty) begin
                    $error("no_segments expected %0d got %0d", e.empty, o_no_segments);
                    error_count++;
                end
            end
        end
    end

    task automatic send_request(t_request r);
        while ($urandom_range(99) < sender_idle_pct) @(negedge i_clk);
        start = 1'b1;
        i_op = r.op; i_seg_index = r.idx;
        i_start_x = r.sx; i_start_y = r.sy; i_end_x = r.ex; i_end_y = r.ey;
        i_left_x = r.lx; i_left_y = r.ly; i_point_x = r.px; i_point_y = r.py;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (r.op == OP_LOAD_CODE) begin
            tbl_sx[r.idx] = r.sx; tbl_sy[r.idx] = r.sy;
            tbl_ex[r.idx] = r.ex; tbl_ey[r.idx] = r.ey;
            tbl_lx[r.idx] = r.lx; tbl_ly[r.idx] = r.ly;
            tbl_written[r.idx] = 1'b1;
            loads_sent++;
        end else begin
            expected_answers.insert(expected_answers.size(),
                                    nearest_segment(r.px, r.py));
            queries_sent++;
        end
        @(negedge i_clk);
        start = 1'b0;
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(5))
            0:       return $urandom();
            1:       return $signed($urandom_range(2 * Q)) - Q;
            2:       return $signed($urandom_range(200)) - 100;
            3:       return ($urandom_range(1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return ($signed($urandom_range(40)) - 20) * Q;
        endcase
    endfunction

    task automatic load_segment(int idx, logic signed [31:0] sx, sy, ex, ey, lx, ly);
        t_request r;
        r = '{op: OP_LOAD_CODE, idx: idx[IDX_W-1:0], sx: sx, sy: sy, ex: ex, ey: ey,
              lx: lx, ly: ly, px: $urandom(), py: $urandom()};
        send_request(r);
    endtask

    task automatic load_random(int idx);
        logic signed [31:0] sx, sy;
        sx = rand_coord(); sy = rand_coord();
        // keep some segments degenerate
        if ($urandom_range(9) == 0) load_segment(idx, sx, sy, sx, sy, rand_coord(), rand_coord());
        else load_segment(idx, sx, sy, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic query_point(logic signed [31:0] px, py);
        t_request r;
        r = '{op: OP_QUERY_CODE, idx: $urandom(), sx: $urandom(), sy: $urandom(),
              ex: $urandom(), ey: $urandom(), lx: $urandom(), ly: $urandom(),
              px: px, py: py};
        send_request(r);
    endtask

    task automatic settle_block();
        while (expected_answers.size() != 0 || busy) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_count(int n);
        settle_block();
        i_cfg_we = 1'b1;
        i_cfg_wdata = n[CNT_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        seg_count = n[CNT_W-1:0];
    endtask

    task automatic fill_table(int n);
        for (int i = 0; i < n && i < NSEG; i++)
            if (!tbl_written[i]) load_random(i);
    endtask

    task automatic test_empty_table();
        set_count(0);
        query_point(32'sh7FFF_FFFF, 32'sh8000_0000);
        query_point(0, 0);
    endtask

    task automatic test_directed_geometry();
        load_segment(0, 0, 0, 10 * Q, 0, 0, 5 * Q);
        load_segment(1, 20 * Q, 20 * Q, 20 * Q, 20 * Q, 21 * Q, 20 * Q);
        load_segment(2, 0, 0, 10 * Q, 0, 0, 5 * Q);
        load_segment(3, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                     32'sh8000_0000, 32'sh7FFF_FFFF);
        load_segment(4, -5 * Q, 5 * Q, -5 * Q, -5 * Q, -6 * Q, 0);
        set_count(1);
        query_point(5 * Q, 3 * Q);
        set_count(5);
        query_point(5 * Q, 3 * Q);
        query_point(5 * Q, -3 * Q);
        query_point(-3 * Q, 0);
        query_point(14 * Q, 0);
        query_point(5 * Q, 0);
        query_point(20 * Q, 21 * Q);
        query_point(32'sh7FFF_FFFF, 32'sh8000_0000);
        query_point(32'sh8000_0000, 32'sh7FFF_FFFF);
        query_point(3, -7);
    endtask

    task automatic test_random_traffic(int idle_pct, int budget);
        int n, queries;
        sender_idle_pct = idle_pct;
        while (budget > 0) begin
            case ($urandom_range(9))
                0:       n = 64;
                1:       n = 127;
                2:       n = $urandom_range(9, 63);
                default: n = $urandom_range(1, 8);
            endcase
            set_count(n);
            fill_table(n);
            queries = (n > 16) ? $urandom_range(1, 2) : $urandom_range(3, 10);
            for (int k = 0; k < queries; k++) begin
                if ($urandom_range(4) == 0) load_random($urandom_range(((n > NSEG) ? NSEG : n) - 1));
                else query_point(rand_coord(), rand_coord());
                budget--;
            end
        end
    endtask

    initial begin
        error_count = 0; cycle_count = 0; queries_sent = 0; loads_sent = 0;
        answers_seen = 0; sender_idle_pct = 0; seg_count = '0;
        foreach (tbl_written[i]) tbl_written[i] = 1'b0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_wdata = '0; start = 1'b0;
        i_op = OP_LOAD_CODE; i_seg_index = '0;
        i_start_x = '0; i_start_y = '0; i_end_x = '0; i_end_y = '0;
        i_left_x = '0; i_left_y = '0; i_point_x = '0; i_point_y = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_empty_table();
        test_directed_geometry();
        test_random_traffic(25, 125);
        test_random_traffic(82, 125);
        test_random_traffic(0, 125);
        set_count(0);
        query_point(rand_coord(), rand_coord());

        settle_block();
        repeat (50) @(negedge i_clk);
        $display("Covered %0d loads and %0d queries, %0d results checked,", loads_sent,
                 queries_sent, answers_seen);
        $display("segment counts from empty through full and above the table size.");
        if (error_count == 0 && expected_answers.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
sv/sns_pkg.sv
sv/sns_ctrl.sv
sv/sns_dp.sv
sv/signed_nearest_segment_distance.sv
sv/sns_chk.sv
tb/tb_top.sv
